// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the serial frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    // default frame store depth
    localparam int BUF_DEPTH_DEF = 64;

    // widest fill count over the supported depth range (up to 256 entries)
    localparam int CNT_W_MAX = 9;

    // frame descriptor queue depth
    localparam int Q_DEPTH = 2;

    // frame bytes and offsets
    localparam logic [7:0] HDR_BYTE  = 8'hEF;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;
    localparam int LEN_OFS  = 5;
    localparam int NODE_OFS = 6;
    localparam int DEV_OFS  = 7;
    localparam int PAY_OFS  = 8;

    // completed frame handed from front to back
    typedef struct packed {
        logic [7:0]           node;
        logic [7:0]           dev;
        logic [CNT_W_MAX-1:0] cnt;
    } t_frame_desc;

    // back status seen by the front, guards store writes
    typedef struct packed {
        logic                 busy;
        logic [CNT_W_MAX-1:0] rd_ptr;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== design/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Small fifo of completed frame descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_queue #(
    parameter int DEPTH = sfd_pkg::Q_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire sfd_pkg::t_frame_desc i_desc,
    input  wire logic                i_pop,
    output sfd_pkg::t_frame_desc     o_desc,
    output logic                     o_full,
    output logic                     o_empty
);

    sfd_pkg::t_frame_desc r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count, n_count;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    assign o_desc  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== design/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Accepts received bytes, tracks the fill count, spots header restarts and
// frame tails, writes the frame store and queues completed frames.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_front #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF,
    localparam int IW = $clog2(BUF_DEPTH),
    localparam int CW = $clog2(BUF_DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rx_valid,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_rx_ready,
    input  wire logic                i_q_full,
    input  wire logic                i_q_empty,
    input  wire sfd_pkg::t_back_stat i_bstat,
    output logic                     o_push,
    output sfd_pkg::t_frame_desc     o_desc,
    output logic                     o_wr_en,
    output logic [IW-1:0]            o_wr_addr,
    output logic [7:0]               o_wr_data
);

    localparam int MW = sfd_pkg::CNT_W_MAX;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_node, n_node;
    logic [7:0]    r_dev, n_dev;

    logic [MW-1:0] cnt_ext;
    logic          below_guard;
    logic          accept;
    logic          is_restart;
    logic          is_tail;
    logic          at_end;

    // the next write lands at r_cnt; keep it below what the back still reads
    assign cnt_ext     = MW'(r_cnt);
    assign below_guard = i_q_empty ? (!i_bstat.busy || (cnt_ext < i_bstat.rd_ptr))
                                   : (cnt_ext < MW'(sfd_pkg::PAY_OFS));
    assign o_rx_ready  = !i_q_full && below_guard;
    assign accept      = i_rx_valid && o_rx_ready;

    // byte classification
    assign is_restart = (i_rx_byte == sfd_pkg::HDR_BYTE) && (r_cnt != '0)
                        && (r_prev == sfd_pkg::HDR_BYTE);
    assign is_tail    = (r_cnt > CW'(sfd_pkg::LEN_OFS))
                        && (i_rx_byte == sfd_pkg::TAIL_BYTE)
                        && ((cnt_ext + MW'(1)) == MW'(r_len));
    assign at_end     = (r_cnt == CW'(BUF_DEPTH));

    assign o_wr_addr = r_cnt[IW-1:0];

    // next state of the fill tracking
    always_comb begin
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_len     = r_len;
        n_node    = r_node;
        n_dev     = r_dev;
        o_wr_en   = 1'b0;
        o_wr_data = i_rx_byte;
        o_push    = 1'b0;
        o_desc.node = (r_cnt == CW'(sfd_pkg::NODE_OFS)) ? sfd_pkg::TAIL_BYTE : r_node;
        o_desc.dev  = (r_cnt == CW'(sfd_pkg::DEV_OFS)) ? sfd_pkg::TAIL_BYTE : r_dev;
        o_desc.cnt  = cnt_ext;
        if (accept) begin
            if (is_restart) begin
                // header bytes at offsets 0 and 1 are never read back
                n_cnt  = CW'(2);
                n_prev = sfd_pkg::HDR_BYTE;
            end else if (is_tail) begin
                n_cnt = '0;
                if (!at_end) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = sfd_pkg::TAIL_BYTE;
                    o_push    = 1'b1;
                    n_node    = o_desc.node;
                    n_dev     = o_desc.dev;
                end
            end else if (at_end) begin
                // overflow drops the partial frame
                n_cnt = '0;
            end else begin
                o_wr_en = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_prev  = i_rx_byte;
                if (r_cnt == CW'(sfd_pkg::LEN_OFS)) begin
                    n_len = i_rx_byte;
                end
                if (r_cnt == CW'(sfd_pkg::NODE_OFS)) begin
                    n_node = i_rx_byte;
                end
                if (r_cnt == CW'(sfd_pkg::DEV_OFS)) begin
                    n_dev = i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // shadow copies of single store offsets
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_len  <= n_len;
        r_node <= n_node;
        r_dev  <= n_dev;
    end

endmodule

`default_nettype wire

// ===== design/sfd_store.sv =====
// ----------------------------------------------------------------------------
// sfd_store
// Frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_store #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF,
    localparam int IW = $clog2(BUF_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Takes completed frames from the queue, reads their payload out of the
// frame store and presents one result per payload byte, or one result with no payload for an empty frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_back #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF,
    localparam int IW = $clog2(BUF_DEPTH),
    localparam int CW = $clog2(BUF_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire sfd_pkg::t_frame_desc i_desc,
    output logic                      o_pop,
    output sfd_pkg::t_back_stat       o_bstat,
    output logic                      o_rd_en,
    output logic [IW-1:0]             o_rd_addr,
    input  wire logic [7:0]           i_rd_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_node_id,
    output logic [7:0]                o_device_id,
    output logic [7:0]                o_payload_byte,
    output logic                      o_has_payload,
    output logic                      o_last
);

    localparam int MW = sfd_pkg::CNT_W_MAX;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_node, n_node;
    logic [7:0]    r_dev, n_dev;
    logic          r_empty, n_empty;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_node, n_out_node;
    logic [7:0]    r_out_dev, n_out_dev;
    logic [7:0]    r_out_pay, n_out_pay;
    logic          r_out_has, n_out_has;
    logic          r_out_last, n_out_last;

    logic          slot_free;
    logic          is_last;

    assign slot_free = !r_out_valid || i_out_ready;
    assign is_last   = r_empty || ((CW'(r_rd) + CW'(1)) == r_cnt);

    assign o_rd_addr      = r_rd;
    assign o_bstat.busy   = (r_state != ST_IDLE) && !r_empty;
    assign o_bstat.rd_ptr = MW'(r_rd);

    // payload read sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_cnt       = r_cnt;
        n_node      = r_node;
        n_dev       = r_dev;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_node  = r_out_node;
        n_out_dev   = r_out_dev;
        n_out_pay   = r_out_pay;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        o_rd_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_node  = i_desc.node;
                    n_dev   = i_desc.dev;
                    n_cnt   = i_desc.cnt[CW-1:0];
                    n_rd    = IW'(sfd_pkg::PAY_OFS);
                    n_empty = (i_desc.cnt <= MW'(sfd_pkg::PAY_OFS));
                    n_state = n_empty ? ST_LOAD : ST_READ;
                end
            end
            ST_READ: begin
                o_rd_en = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = r_node;
                    n_out_dev   = r_dev;
                    n_out_pay   = r_empty ? 8'h00 : i_rd_data;
                    n_out_has   = !r_empty;
                    n_out_last  = is_last;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd    = r_rd + IW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // frame context and result payload
    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_cnt      <= n_cnt;
        r_node     <= n_node;
        r_dev      <= n_dev;
        r_empty    <= n_empty;
        r_out_node <= n_out_node;
        r_out_dev  <= n_out_dev;
        r_out_pay  <= n_out_pay;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_node_id      = r_out_node;
    assign o_device_id    = r_out_dev;
    assign o_payload_byte = r_out_pay;
    assign o_has_payload  = r_out_has;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ===== design/serial_frame_deframer.sv =====
// With the back idle, a completed frame passes the queue and the back's ST_READ and
// ST_LOAD states into the output register; a frame with no payload skips ST_READ.
// The back reads each payload byte through the store's single read port in ST_READ
// and loads it in ST_LOAD before the next read; a stalled output holds it there.
// Input ready drops while the queue is full or the next store write would hit
// payload the back has not yet read. Reset clears the fill count, the queue and
// the output; the frame store keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Collects received bytes into frames and emits node, device and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_deframer #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF,
    localparam int IW = $clog2(BUF_DEPTH)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_node_id,
    output logic [7:0]      o_device_id,
    output logic [7:0]      o_payload_byte,
    output logic            o_has_payload,
    output logic            o_last
);

    sfd_pkg::t_frame_desc push_desc;
    sfd_pkg::t_frame_desc head_desc;
    sfd_pkg::t_back_stat  bstat;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [7:0]           rd_data;

    // byte intake and classification
    sfd_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (q_full),
        .i_q_empty  (q_empty),
        .i_bstat    (bstat),
        .o_push     (push),
        .o_desc     (push_desc),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // completed frames waiting for the back
    sfd_queue #(.DEPTH(sfd_pkg::Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // frame store
    sfd_store #(.BUF_DEPTH(BUF_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // payload emission
    sfd_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_desc         (head_desc),
        .o_pop          (pop),
        .o_bstat        (bstat),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_node_id      (o_node_id),
        .o_device_id    (o_device_id),
        .o_payload_byte (o_payload_byte),
        .o_has_payload  (o_has_payload),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_node_id,
    input wire logic [7:0] o_device_id,
    input wire logic [7:0] o_payload_byte,
    input wire logic       o_has_payload,
    input wire logic       o_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_payload_byte) && $stable(o_last) && $stable(o_has_payload))
        else $error("result payload changed while stalled");

    // an empty frame gives one final result with a zero payload byte
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_payload |-> o_last && (o_payload_byte == 8'h00))
        else $error("empty frame result malformed");

    // a result directly following an accepted non-final one has payload and keeps the frame's node and device
    a_frame_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last ##1 o_out_valid |->
            o_has_payload && (o_node_id == $past(o_node_id))
            && (o_device_id == $past(o_device_id)))
        else $error("frame ids changed inside a frame");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (.*);

`default_nettype wire
